// File: rtl/core/psm_pkg.sv
// ---------------------------------------------------------------------------
// psm_pkg : shared types and constants of the p-code stack machine
// Opcode, operation and fault codes plus sizing constants.
// ---------------------------------------------------------------------------
package psm_pkg;

  localparam int StackDepth   = 1024;
  localparam int ProgramDepth = 256;
  localparam int MaxLevel     = 7;
  localparam int WordWidth    = 32;
  localparam int AddrWidth    = $clog2(StackDepth);
  localparam int TopWidth     = AddrWidth + 1;
  localparam int PcWidth      = $clog2(ProgramDepth);

  typedef enum logic [2:0] {
    OP_LIT = 3'd0, OP_OPR = 3'd1, OP_LOD = 3'd2, OP_STO = 3'd3,
    OP_CAL = 3'd4, OP_INT = 3'd5, OP_JMP = 3'd6, OP_JPC = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    OPR_RTN = 4'd0, OPR_NEG = 4'd1, OPR_ADD = 4'd2, OPR_SUB = 4'd3,
    OPR_MUL = 4'd4, OPR_DIV = 4'd5, OPR_ODD = 4'd6, OPR_MOD = 4'd7,
    OPR_EQL = 4'd8, OPR_NEQ = 4'd9, OPR_LSS = 4'd10, OPR_LEQ = 4'd11,
    OPR_GTR = 4'd12, OPR_GEQ = 4'd13
  } opr_e;

  typedef enum logic [2:0] {
    F_NONE = 3'd0, F_DIV0 = 3'd1, F_OVER = 3'd2, F_UNDER = 3'd3, F_BADOP = 3'd4
  } fault_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WALK, ST_WALKW, ST_RD1, ST_RD2, ST_EXEC, ST_DIV, ST_WR,
    ST_TOPRD, ST_TOPW, ST_OUT
  } state_e;

  // stack memory port request
  typedef struct packed {
    logic                 we;
    logic [AddrWidth-1:0] addr;
    logic [WordWidth-1:0] wdata;
  } mem_req_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// File: rtl/core/psm_stack_ram.sv
// ---------------------------------------------------------------------------
// psm_stack_ram : data stack memory
// One read/write port, registered read data. After reset a clearing pass
// writes the reset contents, one word per cycle, before the port is served.
// ---------------------------------------------------------------------------
module psm_stack_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psm_pkg::mem_req_t             req_i,
  output logic [psm_pkg::WordWidth-1:0] rdata_o
);
  import psm_pkg::*;

  logic [WordWidth-1:0] mem [StackDepth];
  logic [TopWidth-1:0]  fill_q, fill_d;
  logic [WordWidth-1:0] rd_q;
  logic                 clearing;

  assign clearing = (fill_q != TopWidth'(StackDepth));

  // advance the clearing pointer until every word is swept
  always_comb begin
    fill_d = fill_q;
    if (clearing) fill_d = fill_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // sweep in the reset value (word 0 all ones, others zero), then serve the port
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem[fill_q[AddrWidth-1:0]] <= (fill_q == '0) ? '1 : '0;
    end else if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.addr];
  end

  assign rdata_o = rd_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !req_i.we)
    else $error("stack write during clearing pass");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing |=> !clearing)
    else $error("clearing pass restarted");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |=> fill_q == $past(fill_q) + 1'b1)
    else $error("clear sweep skipped an entry");
endmodule

// File: rtl/core/psm_divider.sv
// ---------------------------------------------------------------------------
// psm_divider : iterative unsigned restoring divider
// One quotient bit per cycle over magnitudes; sign fix-up done by caller.
// ---------------------------------------------------------------------------
module psm_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psm_pkg::WordWidth-1:0] dividend_i,
  input  logic [psm_pkg::WordWidth-1:0] divisor_i,
  output psm_pkg::div_ctl_t             ctl_o,
  output logic [psm_pkg::WordWidth-1:0] quot_o,
  output logic [psm_pkg::WordWidth-1:0] rem_o
);
  import psm_pkg::*;

  localparam int CntWidth = $clog2(WordWidth + 1);

  logic [CntWidth-1:0]  cnt_q;
  logic                 busy_q, done_q;
  logic [WordWidth-1:0] q_q, d_q;
  logic [WordWidth:0]   r_q, r_sh, r_sub;

  assign r_sh  = {r_q[WordWidth-1:0], q_q[WordWidth-1]};
  assign r_sub = r_sh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(WordWidth);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntWidth'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift one dividend bit into the partial remainder per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      d_q <= divisor_i;
      r_q <= '0;
    end else if (busy_q) begin
      if (!r_sub[WordWidth]) begin
        r_q <= r_sub;
        q_q <= {q_q[WordWidth-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[WordWidth-2:0], 1'b0};
      end
    end
  end

  assign quot_o      = q_q;
  assign rem_o       = r_q[WordWidth-1:0];
  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == CntWidth'(1) && !start_i |=> done_q)
    else $error("divider missed completion");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
endmodule

// File: rtl/core/pcode_stack_machine_execute.sv
// ---------------------------------------------------------------------------
// pcode_stack_machine_execute : PL/0 p-code execute stage
// Runs one fetched instruction per transaction on a memory-held data stack.
// ---------------------------------------------------------------------------
// channel   dir  tdata fields (lsb up)                         tuser
// s_axis    in   op[2:0] level[5:3] operand[37:6] (40 bits)    -
// m_axis    out  next_pc[7:0] top_value[39:8] top_index[50:40]
//                halted[51] fault[54:52] (56 bits)             -
// Sequence: LOD, STO and CAL first walk one static link per level, CAL then
// writes its frame, and DIV and MOD wait for the bit-serial divider; a halted
// block only reads back the top and answers.
// Reset: a clearing pass writes the stack's reset contents; no instruction
// is taken meanwhile. One instruction in flight; the result register holds
// while m_axis_tready is low, and no new input is taken until it is accepted.
// ---------------------------------------------------------------------------
module pcode_stack_machine_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // op, level, operand
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // next_pc, top_value, top_index, halted, fault
);
  import psm_pkg::*;

  state_e state_q, state_d;

  // architectural registers
  logic [TopWidth-1:0]  top_q, top_d;       // signed top index
  logic [AddrWidth-1:0] base_q, base_d;
  logic [PcWidth-1:0]   pc_q, pc_d;
  logic                 halt_q, halt_d;

  // instruction and working registers
  logic [2:0]           op_q, op_d;
  logic [2:0]           lev_q, lev_d;
  logic [31:0]          opd_q, opd_d;
  logic [AddrWidth-1:0] wb_q, wb_d;          // walked base
  logic [WordWidth-1:0] x_q, x_d, y_q, y_d;
  logic [2:0]           fault_q, fault_d;
  logic [1:0]           sub_q, sub_d;        // sub-step counter
  logic [55:0]          out_q, out_d;
  logic                 ovalid_q, ovalid_d;
  logic                 clr_done_q;
  logic [10:0]          clr_cnt_q;

  mem_req_t             req;
  logic [WordWidth-1:0] rdata;

  div_ctl_t             dctl;
  logic                 dstart;
  logic [WordWidth-1:0] quot, rem, mag_x, mag_y;

  psm_stack_ram u_ram (.clk_i, .rst_ni, .req_i(req), .rdata_o(rdata));

  assign mag_x = x_q[WordWidth-1] ? -x_q : x_q;
  assign mag_y = y_q[WordWidth-1] ? -y_q : y_q;

  psm_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .dividend_i(mag_x), .divisor_i(mag_y),
    .ctl_o(dctl), .quot_o(quot), .rem_o(rem)
  );

  // track the memory clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == 11'(StackDepth)) clr_done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      top_q    <= '1;
      base_q   <= '0;
      pc_q     <= '0;
      halt_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      base_q   <= base_d;
      pc_q     <= pc_d;
      halt_q   <= halt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; lev_q <= lev_d; opd_q <= opd_d; wb_q <= wb_d;
    x_q <= x_d; y_q <= y_d; fault_q <= fault_d; sub_q <= sub_d; out_q <= out_d;
  end

  // helpers
  logic signed [TopWidth:0] t_s;
  logic [PcWidth-1:0]       pc1;
  logic                     tgt_ok, in_acc;
  logic signed [33:0]       sum_ti, addr_s;
  logic [WordWidth-1:0]     r_res;
  logic                     slt_xy, slt_yx;
  logic [PcWidth-1:0]       ra_pc;

  assign t_s    = {top_q[TopWidth-1], top_q};
  assign pc1    = pc_q + 1'b1;
  assign tgt_ok = (opd_q[31:PcWidth] == '0);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign sum_ti = 34'(signed'(t_s)) + 34'(signed'(opd_q));
  assign addr_s = 34'(signed'({1'b0, wb_q})) + 34'(signed'(opd_q));
  assign slt_xy = $signed(x_q) < $signed(y_q);
  assign slt_yx = $signed(y_q) < $signed(x_q);
  assign ra_pc  = x_q[PcWidth-1:0];

  assign s_axis_tready = (state_q == ST_IDLE) && clr_done_q && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  // word read as a link index: must be non-negative and below the stack
  function automatic logic link_ok(input logic [WordWidth-1:0] w);
    link_ok = (w[WordWidth-1:AddrWidth] == '0);
  endfunction

  // first-read address select: frame data, return frame, or second from top
  function automatic logic [1:0] op_d_sel(input logic [2:0] o, input logic [31:0] c);
    if (o == OP_LOD || o == OP_STO)            op_d_sel = 2'd1;
    else if (o == OP_OPR && c == 32'(OPR_RTN)) op_d_sel = 2'd2;
    else                                       op_d_sel = 2'd0;
  endfunction

  always_comb begin
    state_d = state_q; top_d = top_q; base_d = base_q; pc_d = pc_q;
    halt_d = halt_q; ovalid_d = ovalid_q; op_d = op_q; lev_d = lev_q;
    opd_d = opd_q; wb_d = wb_q; x_d = x_q; y_d = y_q; fault_d = fault_q;
    sub_d = sub_q; out_d = out_q;
    req = '0; dstart = 1'b0; r_res = '0;

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    case (opd_q[3:0])
      OPR_ADD: r_res = x_q + y_q;
      OPR_SUB: r_res = x_q - y_q;
      OPR_MUL: r_res = x_q * y_q;
      OPR_EQL: r_res = WordWidth'(x_q == y_q);
      OPR_NEQ: r_res = WordWidth'(x_q != y_q);
      OPR_LSS: r_res = WordWidth'(slt_xy);
      OPR_LEQ: r_res = WordWidth'(!slt_yx);
      OPR_GTR: r_res = WordWidth'(slt_yx);
      OPR_GEQ: r_res = WordWidth'(!slt_xy);
      OPR_DIV: r_res = (x_q[WordWidth-1] ^ y_q[WordWidth-1]) ? -quot : quot;
      OPR_MOD: r_res = x_q[WordWidth-1] ? -rem : rem;
      default: r_res = '0;
    endcase

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = s_axis_tdata[2:0];
          lev_d   = s_axis_tdata[5:3];
          opd_d   = s_axis_tdata[37:6];
          wb_d    = base_q;
          fault_d = F_NONE;
          sub_d   = '0;
          if (halt_q) state_d = ST_TOPRD;
          else if (s_axis_tdata[2:0] == OP_LOD || s_axis_tdata[2:0] == OP_STO ||
                   s_axis_tdata[2:0] == OP_CAL) state_d = ST_WALK;
          else state_d = ST_RD1;
        end
      end
      // follow one static link per ST_WALK/ST_WALKW pass
      ST_WALK: begin
        if (lev_q == '0) state_d = ST_RD1;
        else begin
          req.addr = wb_q;
          state_d  = ST_WALKW;
        end
      end
      ST_WALKW: begin
        if (!link_ok(rdata)) begin
          fault_d = F_UNDER;
          state_d = ST_TOPRD;
        end else begin
          wb_d    = rdata[AddrWidth-1:0];
          lev_d   = lev_q - 1'b1;
          state_d = ST_WALK;
        end
      end
      // operand reads: x from first address, y from second
      ST_RD1: begin
        state_d = ST_RD2;
        case (op_d_sel(op_q, opd_q))
          2'd1: req.addr = addr_s[AddrWidth-1:0];
          2'd2: req.addr = base_q + 2'd2;
          default: req.addr = top_q[AddrWidth-1:0] - 1'b1;
        endcase
      end
      ST_RD2: begin
        x_d      = rdata;
        req.addr = (op_q == OP_OPR && opd_q == 32'(OPR_RTN)) ? base_q + 1'b1
                                                             : top_q[AddrWidth-1:0];
        state_d  = ST_EXEC;
        sub_d    = '0;
      end
      ST_EXEC: begin
        if (sub_q == '0) begin
          y_d   = rdata;
          sub_d = 2'd1;
        end else begin
          state_d = ST_WR;
          case (op_q)
            OP_LIT: begin
              if (t_s + 1 >= StackDepth) fault_d = F_OVER;
              else begin
                req = '{we: 1'b1, addr: top_q[AddrWidth-1:0] + 1'b1, wdata: opd_q};
                top_d = top_q + 1'b1; pc_d = pc1;
              end
            end
            OP_LOD: begin
              if (addr_s < 0 || addr_s >= StackDepth) fault_d = F_UNDER;
              else if (t_s + 1 >= StackDepth) fault_d = F_OVER;
              else begin
                req = '{we: 1'b1, addr: top_q[AddrWidth-1:0] + 1'b1, wdata: x_q};
                top_d = top_q + 1'b1; pc_d = pc1;
              end
            end
            OP_STO: begin
              if (addr_s < 0 || addr_s >= StackDepth) fault_d = F_UNDER;
              else if (t_s < 0) fault_d = F_UNDER;
              else begin
                req = '{we: 1'b1, addr: addr_s[AddrWidth-1:0], wdata: y_q};
                top_d = top_q - 1'b1; pc_d = pc1;
              end
            end
            OP_CAL: begin
              if (!tgt_ok) fault_d = F_UNDER;
              else if (t_s + 3 >= StackDepth) fault_d = F_OVER;
              else begin
                req = '{we: 1'b1, addr: top_q[AddrWidth-1:0] + 1'b1,
                        wdata: WordWidth'(wb_q)};
                sub_d = 2'd2;
              end
            end
            OP_INT: begin
              if (sum_ti >= StackDepth) fault_d = F_OVER;
              else if (sum_ti < -1) fault_d = F_UNDER;
              else begin
                top_d = sum_ti[TopWidth-1:0]; pc_d = pc1;
              end
            end
            OP_JMP: begin
              if (!tgt_ok) fault_d = F_UNDER;
              else pc_d = opd_q[PcWidth-1:0];
            end
            OP_JPC: begin
              if (t_s < 0) fault_d = F_UNDER;
              else if (y_q == '0) begin
                if (!tgt_ok) fault_d = F_UNDER;
                else begin
                  pc_d = opd_q[PcWidth-1:0]; top_d = top_q - 1'b1;
                end
              end else begin
                pc_d = pc1; top_d = top_q - 1'b1;
              end
            end
            default: begin // OPR
              if (opd_q == 32'(OPR_RTN)) begin
                if ({1'b0, base_q} + 2 >= StackDepth) fault_d = F_UNDER;
                else if (!(x_q[WordWidth-1:PcWidth] == '0) || !link_ok(y_q))
                  fault_d = F_UNDER;
                else begin
                  top_d  = {1'b0, base_q} - 1'b1;
                  pc_d   = ra_pc;
                  base_d = y_q[AddrWidth-1:0];
                  if (ra_pc == '0) halt_d = 1'b1;
                end
              end else if (opd_q == 32'(OPR_NEG) || opd_q == 32'(OPR_ODD)) begin
                if (t_s < 0) fault_d = F_UNDER;
                else begin
                  req = '{we: 1'b1, addr: top_q[AddrWidth-1:0],
                          wdata: (opd_q == 32'(OPR_NEG)) ? -y_q : WordWidth'(y_q[0])};
                  pc_d = pc1;
                end
              end else if (opd_q[31:4] != '0 || opd_q[3:0] > 4'(OPR_GEQ)) begin
                fault_d = F_BADOP;
              end else if (t_s < 1) fault_d = F_UNDER;
              else if ((opd_q == 32'(OPR_DIV) || opd_q == 32'(OPR_MOD)) &&
                       y_q == '0) fault_d = F_DIV0;
              else if (opd_q == 32'(OPR_DIV) || opd_q == 32'(OPR_MOD)) begin
                if (sub_q == 2'd1) begin
                  dstart = 1'b1; sub_d = 2'd3; state_d = ST_DIV;
                end
              end else begin
                req = '{we: 1'b1, addr: top_q[AddrWidth-1:0] - 1'b1, wdata: r_res};
                top_d = top_q - 1'b1; pc_d = pc1;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        if (dctl.done) begin
          req = '{we: 1'b1, addr: top_q[AddrWidth-1:0] - 1'b1, wdata: r_res};
          top_d = top_q - 1'b1; pc_d = pc1;
          state_d = ST_WR;
        end
      end
      // finish a call frame: saved base and return address; other instructions go on to read the top
      ST_WR: begin
        if (sub_q == 2'd2) begin
          req = '{we: 1'b1, addr: top_q[AddrWidth-1:0] + 2'd2,
                  wdata: WordWidth'(base_q)};
          sub_d = 2'd0;
          state_d = ST_TOPW;
        end else state_d = ST_TOPRD;
      end
      ST_TOPW: begin
        req = '{we: 1'b1, addr: top_q[AddrWidth-1:0] + 2'd3, wdata: WordWidth'(pc1)};
        base_d  = top_q[AddrWidth-1:0] + 1'b1;
        pc_d    = opd_q[PcWidth-1:0];
        state_d = ST_TOPRD;
      end
      ST_TOPRD: begin
        req.addr = top_q[AddrWidth-1:0];
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        out_d = {1'b0, fault_q, halt_q, top_q,
                 top_q[TopWidth-1] ? {WordWidth{1'b0}} : rdata, pc_q};
        ovalid_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted transaction not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |=> m_axis_tvalid)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q != F_NONE && state_q == ST_WR |-> !req.we)
    else $error("faulting instruction wrote the stack");
endmodule
